// ----- hdl/mep_pkg.sv -----
// Shared constants, command and status types and fixed-point helpers for the escape-time block.
package mep_pkg;

  // Fixed-point format and loop limits
  localparam int WORD_W      = 32;
  localparam int FRAC_BITS   = 25;
  localparam int MAX_ITER    = 100;
  localparam int COUNT_W     = $clog2(MAX_ITER + 1);
  localparam int LUT_DEPTH   = 2 ** COUNT_W;

  // Pixel span is an odd factor times a power of two
  localparam int SPAN_SHIFT  = 7;
  localparam int SPAN_ODD    = 3;
  localparam int SPAN_PIXELS = SPAN_ODD << SPAN_SHIFT;

  // Field widths
  localparam int COL_W       = 9;
  localparam int ROW_W       = 8;
  localparam int COLOUR_W    = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;

  // Pixel mapping: scale times column, magnitude, then divide by SPAN_ODD one byte a cycle
  localparam int PROD_W      = WORD_W + COL_W + 1;
  localparam int MAG_W       = WORD_W + COL_W - 1;
  localparam int DIV_DIG_W   = 8;
  localparam int DIV_W       = ((MAG_W - SPAN_SHIFT + DIV_DIG_W - 1) / DIV_DIG_W) * DIV_DIG_W;
  localparam int DIV_STEPS   = DIV_W / DIV_DIG_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int REM_W       = $clog2(SPAN_ODD);

  // Reciprocal of SPAN_ODD: exact floor for every remainder-and-byte value
  localparam int DIV_RECIP_SHIFT = DIV_DIG_W + REM_W + 1;
  localparam int DIV_RECIP       = ((1 << DIV_RECIP_SHIFT) + SPAN_ODD - 1) / SPAN_ODD;
  localparam int DIV_RECIP_W     = $clog2(DIV_RECIP + 1);

  localparam logic signed [WORD_W-1:0] ONE     = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] FOUR    = ONE << 2;
  localparam logic signed [WORD_W-1:0] QUARTER = ONE >>> 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_SCALE  = 2'd0,
    REG_CENTER_REAL = 2'd1,
    REG_CENTER_IMAG = 2'd2
  } mep_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic map;
    logic card_x;
    logic card_q;
    logic card_t;
    logic iter_step;
    logic out_load;
  } mep_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;
    logic iter_done;
    logic out_free;
  } mep_stat_t;

  // Fixed-point product: exact 64-bit, floor shift, wrapped to a word
  function automatic logic signed [WORD_W-1:0] mulq(input logic signed [WORD_W-1:0] a,
                                                    input logic signed [WORD_W-1:0] b);
    logic signed [2*WORD_W-1:0] p;
    p = a * b;
    return p[FRAC_BITS +: WORD_W];
  endfunction

  // One triangle channel of the colour map
  function automatic longint tri_level(input longint peak, input longint centre,
                                       input longint frac, input longint one);
    longint d;
    longint v;
    d = centre - frac;
    if (d < 0) d = -d;
    v = peak - d;
    v = (v > 0) ? 6 * v : 0;
    return (v > one) ? one : v;
  endfunction

  // RGB565 colour of an iteration count, evaluated with constant arguments only
  function automatic logic [COLOUR_W-1:0] colour_of(input int count);
    longint one;
    longint frac;
    longint r;
    longint g;
    longint b;
    longint rb;
    longint gb;
    longint bb;
    one  = longint'(1) <<< FRAC_BITS;
    frac = (longint'(count) * one) / MAX_ITER;
    r    = tri_level(one >>> 2, one >>> 2, frac, one);
    g    = tri_level(one / 3, one >>> 1, frac, one);
    b    = tri_level(one >>> 2, (one >>> 2) + (one >>> 1), frac, one);
    if (frac < (one >>> 2)) r = (r + one) >>> 1;
    if (frac > (one >>> 2) + (one >>> 1)) b = (b + one) >>> 1;
    rb = (31 * r) >>> FRAC_BITS;
    gb = (63 * g) >>> FRAC_BITS;
    bb = (31 * b) >>> FRAC_BITS;
    return {5'(rb), 6'(gb), 5'(bb)};
  endfunction

endpackage

// ----- hdl/mep_ctrl.sv -----
// Sequencing state machine: divide, mapping, cardioid test, iteration and result hand-off.
module mep_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  mep_pkg::mep_stat_t  stat,
  output mep_pkg::mep_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MAP,
    S_CARD_X,
    S_CARD_Q,
    S_CARD_T,
    S_ITER,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;

  assign in_tready = in_ready_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_MAP;
      end
      S_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = S_CARD_X;
      end
      S_CARD_X: begin
        cmd.card_x = 1'b1;
        state_nxt  = S_CARD_Q;
      end
      S_CARD_Q: begin
        cmd.card_q = 1'b1;
        state_nxt  = S_CARD_T;
      end
      S_CARD_T: begin
        cmd.card_t = 1'b1;
        state_nxt  = S_ITER;
      end
      S_ITER: begin
        if (stat.iter_done) state_nxt = S_DONE;
        else cmd.iter_step = 1'b1;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

endmodule

// ----- hdl/mep_dp.sv -----
// Datapath: pixel mapping with divide by span, cardioid test, z iteration, colour and output register.
module mep_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mep_pkg::mep_cmd_t                    cmd,
  output mep_pkg::mep_stat_t                   stat,
  input  logic signed [mep_pkg::WORD_W-1:0]    view_scale,
  input  logic signed [mep_pkg::WORD_W-1:0]    center_real,
  input  logic signed [mep_pkg::WORD_W-1:0]    center_imag,
  input  logic        [mep_pkg::COL_W-1:0]     pixel_column,
  input  logic        [mep_pkg::ROW_W-1:0]     pixel_row,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic        [mep_pkg::COUNT_W-1:0]   iteration_count,
  output logic                                 inside_cardioid,
  output logic        [mep_pkg::COLOUR_W-1:0]  pixel_colour
);

  localparam int W   = mep_pkg::WORD_W;
  localparam int DW  = mep_pkg::DIV_W;
  localparam int DGW = mep_pkg::DIV_DIG_W;
  localparam int RW  = mep_pkg::REM_W;
  localparam int VW  = mep_pkg::REM_W + mep_pkg::DIV_DIG_W;
  localparam int PW  = VW + mep_pkg::DIV_RECIP_W;

  // Colour map, one entry per count
  logic [mep_pkg::COLOUR_W-1:0] colour_lut [mep_pkg::LUT_DEPTH];

  for (genvar g = 0; g < mep_pkg::LUT_DEPTH; g++) begin : g_lut
    assign colour_lut[g] = mep_pkg::colour_of(g);
  end

  // Divider lanes: 0 is the column, 1 the row
  logic [DW-1:0]                   dq_r   [2];
  logic [DW-1:0]                   dq_nxt [2];
  logic [RW-1:0]                   rem_r  [2];
  logic [RW-1:0]                   rem_nxt[2];
  logic                            neg_r  [2];
  logic                            neg_nxt[2];
  logic [mep_pkg::DIV_CNT_W-1:0]   div_cnt_r;
  logic [mep_pkg::DIV_CNT_W-1:0]   div_cnt_nxt;

  // Iteration state
  logic signed [W-1:0]             cr_r, cr_nxt;
  logic signed [W-1:0]             ci_r, ci_nxt;
  logic signed [W-1:0]             zr_r, zr_nxt;
  logic signed [W-1:0]             zi_r, zi_nxt;
  logic signed [W-1:0]             q_r, q_nxt;
  logic [mep_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic                            inside_r, inside_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [mep_pkg::COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic                            out_inside_r, out_inside_nxt;
  logic [mep_pkg::COLOUR_W-1:0]    out_colour_r, out_colour_nxt;

  // Combinational helpers
  logic signed [mep_pkg::PROD_W-1:0] prod_col, prod_row;
  logic        [mep_pkg::PROD_W-1:0] mag_col, mag_row;
  logic        [VW-1:0]              div_v    [2];
  logic        [PW-1:0]              div_prod [2];
  logic        [DGW-1:0]             div_digit[2];
  logic        [W-1:0]               quot_w   [2];
  logic signed [W-1:0]               sr, si, sx, sum_sq, card_diff;
  logic                              escape_ok;

  // Scale times pixel index and its magnitude
  always_comb begin
    prod_col = view_scale * $signed({1'b0, pixel_column});
    prod_row = view_scale * $signed({1'b0, pixel_row});
    mag_col  = prod_col[mep_pkg::PROD_W-1] ? unsigned'(-prod_col) : unsigned'(prod_col);
    mag_row  = prod_row[mep_pkg::PROD_W-1] ? unsigned'(-prod_row) : unsigned'(prod_row);
  end

  // One quotient byte of the divide by the odd span factor, and signed quotient
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      div_v[l]     = {rem_r[l], dq_r[l][DW-1 -: DGW]};
      div_prod[l]  = PW'(div_v[l]) * PW'(mep_pkg::DIV_RECIP);
      div_digit[l] = div_prod[l][mep_pkg::DIV_RECIP_SHIFT +: DGW];
      quot_w[l]    = W'(neg_r[l] ? (DW'(0) - dq_r[l]) : dq_r[l]);
    end
  end

  // Shared squarer and cross product on z
  always_comb begin
    sr        = mep_pkg::mulq(zr_r, zr_r);
    si        = mep_pkg::mulq(zi_r, zi_r);
    sx        = mep_pkg::mulq({zr_r[W-2:0], 1'b0}, zi_r);
    sum_sq    = sr + si;
    escape_ok = sum_sq < mep_pkg::FOUR;
    card_diff = sr - (q_r >>> 2);
  end

  assign stat.div_last  = (div_cnt_r == mep_pkg::DIV_CNT_W'(mep_pkg::DIV_STEPS - 1));
  assign stat.iter_done = inside_r || !escape_ok ||
                          (count_r == mep_pkg::COUNT_W'(mep_pkg::MAX_ITER));
  assign stat.out_free  = !out_valid_r || out_tready;

  // Next values
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dq_nxt[l]  = dq_r[l];
      rem_nxt[l] = rem_r[l];
      neg_nxt[l] = neg_r[l];
    end
    div_cnt_nxt    = div_cnt_r;
    cr_nxt         = cr_r;
    ci_nxt         = ci_r;
    zr_nxt         = zr_r;
    zi_nxt         = zi_r;
    q_nxt          = q_r;
    count_nxt      = count_r;
    inside_nxt     = inside_r;
    out_count_nxt  = out_count_r;
    out_inside_nxt = out_inside_r;
    out_colour_nxt = out_colour_r;

    if (cmd.load) begin
      dq_nxt[0]   = DW'(mag_col >> mep_pkg::SPAN_SHIFT);
      dq_nxt[1]   = DW'(mag_row >> mep_pkg::SPAN_SHIFT);
      rem_nxt[0]  = '0;
      rem_nxt[1]  = '0;
      neg_nxt[0]  = prod_col[mep_pkg::PROD_W-1];
      neg_nxt[1]  = prod_row[mep_pkg::PROD_W-1];
      div_cnt_nxt = '0;
    end else if (cmd.div_step) begin
      for (int l = 0; l < 2; l++) begin
        dq_nxt[l]  = {dq_r[l][DW-DGW-1:0], div_digit[l]};
        rem_nxt[l] = RW'(div_v[l] - VW'(div_digit[l] * mep_pkg::SPAN_ODD));
      end
      div_cnt_nxt = div_cnt_r + 1'b1;
    end

    // Point c from the view centre and scaled pixel
    if (cmd.map) begin
      cr_nxt = center_real - (view_scale >>> 1) + signed'(quot_w[0]);
      ci_nxt = center_imag - (view_scale >>> 2) + signed'(quot_w[1]);
    end

    // Cardioid test in three steps, then z iteration
    if (cmd.card_x) begin
      zr_nxt = cr_r - mep_pkg::QUARTER;
      zi_nxt = ci_r;
    end else if (cmd.card_q) begin
      q_nxt  = sum_sq;
      zr_nxt = sum_sq + (zr_r >>> 1);
    end else if (cmd.card_t) begin
      inside_nxt = card_diff[W-1];
      count_nxt  = card_diff[W-1] ? mep_pkg::COUNT_W'(mep_pkg::MAX_ITER) : '0;
      zr_nxt     = '0;
      zi_nxt     = '0;
    end else if (cmd.iter_step) begin
      zr_nxt    = sr - si + cr_r;
      zi_nxt    = sx + ci_r;
      count_nxt = count_r + 1'b1;
    end

    // Result register
    if (cmd.out_load) begin
      out_count_nxt  = count_r;
      out_inside_nxt = inside_r;
      out_colour_nxt = colour_lut[count_r];
    end
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      dq_r[l]  <= dq_nxt[l];
      rem_r[l] <= rem_nxt[l];
      neg_r[l] <= neg_nxt[l];
    end
    cr_r         <= cr_nxt;
    ci_r         <= ci_nxt;
    zr_r         <= zr_nxt;
    zi_r         <= zi_nxt;
    q_r          <= q_nxt;
    count_r      <= count_nxt;
    inside_r     <= inside_nxt;
    out_count_r  <= out_count_nxt;
    out_inside_r <= out_inside_nxt;
    out_colour_r <= out_colour_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign iteration_count = out_count_r;
  assign inside_cardioid = out_inside_r;
  assign pixel_colour    = out_colour_r;

endmodule

// ----- hdl/mandelbrot_escape_time_pixel.sv -----
// Top level: configuration registers, stream packing and the controller and datapath.
// Evaluates one pixel at a time. A pixel maps to c in signed Q6.25 from the view scale and
// centre, is tested against the main cardioid, and otherwise z = z*z + c is iterated until
// |z|^2 reaches 4 or 100 iterations have run; the count selects an RGB565 colour. A pixel
// passes through the divide by three in the pixel mapping, one quotient byte a cycle through
// a small reciprocal multiply, then the mapping step, the cardioid test and the escape loop,
// which runs one iteration a cycle through three 32x32 fixed-point multipliers and does not
// run for a point inside the cardioid. The finished result sits in an output register, so
// the next pixel is taken while it waits. Configuration writes are always accepted and
// should only be made while no pixel is in flight.
module mandelbrot_escape_time_pixel (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // pixel_column [8:0], pixel_row [16:9], zero [23:17]
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [mep_pkg::IN_TDATA_W-1:0]        in_tdata,
  // iteration_count [6:0], pixel_colour [22:7], zero [23]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [mep_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // inside_cardioid [0]
  output logic                                  out_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mep_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mep_pkg::WORD_W-1:0]            cfg_data
);

  logic signed [mep_pkg::WORD_W-1:0]   view_scale_r, view_scale_nxt;
  logic signed [mep_pkg::WORD_W-1:0]   center_real_r, center_real_nxt;
  logic signed [mep_pkg::WORD_W-1:0]   center_imag_r, center_imag_nxt;

  mep_pkg::mep_cmd_t                   cmd;
  mep_pkg::mep_stat_t                  stat;
  logic [mep_pkg::COUNT_W-1:0]         iteration_count;
  logic [mep_pkg::COLOUR_W-1:0]        pixel_colour;
  logic                                inside_cardioid;

  assign cfg_ready = 1'b1;

  // Register write decode; unused indexes are dropped
  always_comb begin
    view_scale_nxt  = view_scale_r;
    center_real_nxt = center_real_r;
    center_imag_nxt = center_imag_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mep_pkg::REG_VIEW_SCALE:  view_scale_nxt  = cfg_data;
        mep_pkg::REG_CENTER_REAL: center_real_nxt = cfg_data;
        mep_pkg::REG_CENTER_IMAG: center_imag_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_scale_r  <= mep_pkg::FOUR;
      center_real_r <= '0;
      center_imag_r <= '0;
    end else begin
      view_scale_r  <= view_scale_nxt;
      center_real_r <= center_real_nxt;
      center_imag_r <= center_imag_nxt;
    end
  end

  mep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mep_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .view_scale      (view_scale_r),
    .center_real     (center_real_r),
    .center_imag     (center_imag_r),
    .pixel_column    (in_tdata[mep_pkg::COL_W-1:0]),
    .pixel_row       (in_tdata[mep_pkg::COL_W +: mep_pkg::ROW_W]),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .iteration_count (iteration_count),
    .inside_cardioid (inside_cardioid),
    .pixel_colour    (pixel_colour)
  );

  // Result packing
  assign out_tdata = {1'b0, pixel_colour, iteration_count};
  assign out_tuser = inside_cardioid;

  // One pixel in flight: no input transaction straight after another
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a pixel is in flight");

  // Count never passes the iteration limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[mep_pkg::COUNT_W-1:0] <=
                    mep_pkg::COUNT_W'(mep_pkg::MAX_ITER)))
    else $error("iteration count above limit");

  // A point inside the cardioid reports the full count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[mep_pkg::COUNT_W-1:0] == mep_pkg::COUNT_W'(mep_pkg::MAX_ITER)))
    else $error("cardioid point without full count");

endmodule

// ----- tb/mandelbrot_escape_time_pixel_tb.sv -----
// Self-checking testbench for the escape-time pixel block: stream stimulus, predictor and scoreboard.
module mandelbrot_escape_time_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FX_ONE  = 1 <<< mep_pkg::FRAC_BITS;
  localparam int FX_FOUR = FX_ONE <<< 2;
  localparam logic [mep_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 150;
  localparam int ITEMS_PER_VIEW = 46;
  localparam int VIEWS_PER_MODE = 4;
  localparam longint TIMEOUT_NS = 2_000_000;

  // Expected result of one pixel
  typedef struct {
    logic [8:0]  col;
    logic [7:0]  row;
    logic [6:0]  count;
    logic        in_card;
    logic [15:0] colour;
  } pixel_result_t;

  // Scoreboard: view registers, escape-time predictor and the pending results
  class pixel_scoreboard;
    int scale  = FX_ONE <<< 2;
    int cen_re = 0;
    int cen_im = 0;
    pixel_result_t expected_q[$];
    int unsigned n_pixels;
    int unsigned n_checked;
    int unsigned n_inside;
    int unsigned n_bounded;
    int unsigned n_errors;

    function void set_register(logic [mep_pkg::CFG_IDX_W-1:0] idx,
                               logic [mep_pkg::WORD_W-1:0] value);
      case (idx)
        mep_pkg::REG_VIEW_SCALE:  scale  = value;
        mep_pkg::REG_CENTER_REAL: cen_re = value;
        mep_pkg::REG_CENTER_IMAG: cen_im = value;
        default: ;
      endcase
    endfunction

    // Exact 64-bit product, floor shift, wrapped back to a word
    function int fx_mul(int a, int b);
      longint prod;
      prod = longint'(a) * longint'(b);
      return int'(prod >>> mep_pkg::FRAC_BITS);
    endfunction

    // Pixel index to plane coordinate; quotient truncates toward zero
    function int map_axis(int centre, int offset, int pix);
      longint quot;
      quot = (longint'(scale) * longint'(pix)) / longint'(mep_pkg::SPAN_PIXELS);
      return centre - offset + int'(quot);
    endfunction

    function bit in_main_cardioid(int cr, int ci);
      int x;
      int q;
      int t;
      x = cr - (FX_ONE >>> 2);
      q = fx_mul(x, x) + fx_mul(ci, ci);
      t = q + (x >>> 1);
      return (fx_mul(t, t) - (q >>> 2)) < 0;
    endfunction

    function longint ramp(longint peak, longint centre, longint frac, longint one);
      longint gap_len;
      longint level;
      gap_len = centre - frac;
      if (gap_len < 0) gap_len = -gap_len;
      level = peak - gap_len;
      level = (level > 0) ? 6 * level : 0;
      return (level > one) ? one : level;
    endfunction

    // Triangle colour map to RGB565
    function logic [15:0] rgb565_of(int count);
      longint one;
      longint frac;
      longint r;
      longint g;
      longint b;
      one  = longint'(1) <<< mep_pkg::FRAC_BITS;
      frac = (longint'(count) * one) / mep_pkg::MAX_ITER;
      r = ramp(one >>> 2, one >>> 2, frac, one);
      g = ramp(one / 3, one >>> 1, frac, one);
      b = ramp(one >>> 2, (one >>> 2) + (one >>> 1), frac, one);
      if (frac < (one >>> 2)) r = (r + one) >>> 1;
      if (frac > (one >>> 2) + (one >>> 1)) b = (b + one) >>> 1;
      r = (31 * r) >>> mep_pkg::FRAC_BITS;
      g = (63 * g) >>> mep_pkg::FRAC_BITS;
      b = (31 * b) >>> mep_pkg::FRAC_BITS;
      return {r[4:0], g[5:0], b[4:0]};
    endfunction

    // Predict the result of an accepted pixel transaction
    function void note_pixel(logic [8:0] col, logic [7:0] row);
      pixel_result_t res;
      int cr;
      int ci;
      int zr;
      int zi;
      int zr2;
      int zi2;
      int nr;
      int count;
      cr = map_axis(cen_re, scale >>> 1, int'(col));
      ci = map_axis(cen_im, scale >>> 2, int'(row));
      count = 0;
      res.in_card = in_main_cardioid(cr, ci);
      if (res.in_card) begin
        count = mep_pkg::MAX_ITER;
      end else begin
        zr = 0; zi = 0; zr2 = 0; zi2 = 0;
        while (count < mep_pkg::MAX_ITER && (zr2 + zi2) < FX_FOUR) begin
          nr  = zr2 - zi2 + cr;
          zi  = fx_mul(zr <<< 1, zi) + ci;
          zr  = nr;
          zr2 = fx_mul(zr, zr);
          zi2 = fx_mul(zi, zi);
          count++;
        end
      end
      res.col    = col;
      res.row    = row;
      res.count  = count[6:0];
      res.colour = rgb565_of(count);
      expected_q.push_back(res);
      n_pixels++;
      if (res.in_card) n_inside++;
      if (count == mep_pkg::MAX_ITER) n_bounded++;
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(logic [mep_pkg::OUT_TDATA_W-1:0] tdata, logic tuser);
      pixel_result_t res;
      if (expected_q.size() == 0) begin
        $error("result with no pixel pending: tdata %h tuser %b", tdata, tuser);
        n_errors++;
        return;
      end
      res = expected_q.pop_front();
      n_checked++;
      if (tdata[6:0] !== res.count) begin
        $error("iteration_count (col %0d row %0d): expected %0d, actual %0d",
               res.col, res.row, res.count, tdata[6:0]);
        n_errors++;
      end
      if (tuser !== res.in_card) begin
        $error("inside_cardioid (col %0d row %0d): expected %0d, actual %0d",
               res.col, res.row, res.in_card, tuser);
        n_errors++;
      end
      if (tdata[22:7] !== res.colour) begin
        $error("pixel_colour (col %0d row %0d): expected %h, actual %h",
               res.col, res.row, res.colour, tdata[22:7]);
        n_errors++;
      end
      if (tdata[23] !== 1'b0) begin
        $error("tdata padding: expected 0, actual %b", tdata[23]);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flush_leftovers();
      foreach (expected_q[i]) begin
        $error("no result for pixel col %0d row %0d", expected_q[i].col, expected_q[i].row);
        n_errors++;
      end
      expected_q.delete();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [mep_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [mep_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [mep_pkg::WORD_W-1:0]      cfg_data;

  int in_idle_pct;
  int out_stall_pct;
  int unsigned n_cfg_writes;
  pixel_scoreboard sb;

  mandelbrot_escape_time_pixel u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // One pixel transaction, with random idle cycles ahead of it
  task automatic send_pixel(input logic [8:0] col, input logic [7:0] row);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, row, col};
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(col, row);
  endtask

  // One register write transaction
  task automatic write_reg(input logic [mep_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mep_pkg::WORD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, value);
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_view(input int scale, input int re, input int im);
    write_reg(mep_pkg::REG_VIEW_SCALE, scale);
    write_reg(mep_pkg::REG_CENTER_REAL, re);
    write_reg(mep_pkg::REG_CENTER_IMAG, im);
  endtask

  // Stop sending and wait for every pending result
  task automatic drain_results();
    int waited;
    @(negedge clk);
    in_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) sb.flush_leftovers();
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 0;
      3:       return 1;
      default: return -1;
    endcase
  endfunction

  // Random view: mostly zoomed onto the set boundary, sometimes wild or extreme
  task automatic random_view();
    int kind;
    int scale;
    int re;
    int im;
    kind = $urandom_range(9);
    if (kind <= 5) begin
      scale = (FX_ONE <<< 2) >>> $urandom_range(14);
      if ($urandom_range(7) == 0) scale = -scale;
      case ($urandom_range(3))
        0:       begin re = -25165824; im = 3355443;  end  // seahorse valley
        1:       begin re = -41943040; im = 0;        end  // period-two bulb edge
        2:       begin re = 9395241;   im = 0;        end  // cusp
        default: begin re = -3355443;  im = 21810380; end  // upper filaments
      endcase
      re = re + int'($urandom_range(1 << 20)) - (1 << 19);
      im = im + int'($urandom_range(1 << 20)) - (1 << 19);
    end else if (kind <= 7) begin
      scale = $urandom();
      re    = $urandom();
      im    = $urandom();
    end else begin
      scale = pick_extreme();
      re    = pick_extreme();
      im    = pick_extreme();
    end
    set_view(scale, re, im);
    if ($urandom_range(5) == 0) write_reg(REG_UNUSED, $urandom());
  endtask

  task automatic random_pixel();
    logic [8:0] col;
    logic [7:0] row;
    col = $urandom_range(511);
    row = $urandom_range(255);
    if ($urandom_range(9) == 0) col = $urandom_range(1) ? 9'd511 : 9'd0;
    if ($urandom_range(9) == 0) row = $urandom_range(1) ? 8'd255 : 8'd0;
    send_pixel(col, row);
  endtask

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("mandelbrot_escape_time_pixel_tb NOT OK");
    $finish;
  end

  // Main sequence
  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    n_cfg_writes  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset view: corners, cardioid, bulb, cusp, real-axis tip, alternating bits
    send_pixel(9'd0, 8'd0);
    send_pixel(9'd511, 8'd255);
    send_pixel(9'd0, 8'd255);
    send_pixel(9'd511, 8'd0);
    send_pixel(9'd192, 8'd64);
    send_pixel(9'd96, 8'd96);
    send_pixel(9'd216, 8'd96);
    send_pixel(9'd0, 8'd96);
    send_pixel(9'd341, 8'd170);
    send_pixel(9'd170, 8'd85);
    drain_results();

    // Zero scale collapses the view onto the centre
    write_reg(mep_pkg::REG_VIEW_SCALE, 32'd0);
    send_pixel(9'd0, 8'd0);
    send_pixel(9'd511, 8'd255);
    drain_results();

    // Negative scale mirrors the view
    write_reg(mep_pkg::REG_VIEW_SCALE, -(FX_ONE <<< 2));
    send_pixel(9'd192, 8'd64);
    send_pixel(9'd0, 8'd0);
    drain_results();

    // Extreme registers: mapping and iterates wrap
    set_view(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_pixel(9'd511, 8'd255);
    send_pixel(9'd0, 8'd0);
    send_pixel(9'd300, 8'd200);
    drain_results();

    // Write to an unused index leaves the view alone
    write_reg(REG_UNUSED, 32'h1234_5678);
    send_pixel(9'd96, 8'd96);
    drain_results();

    // Random views and pixels under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin in_idle_pct = 20; out_stall_pct = 52; end
        1:       begin in_idle_pct = 52; out_stall_pct = 20; end
        default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      endcase
      for (int v = 0; v < VIEWS_PER_MODE; v++) begin
        random_view();
        repeat (ITEMS_PER_VIEW) random_pixel();
        drain_results();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d pixels over %0d register writes.",
             sb.n_checked, sb.n_pixels, n_cfg_writes);
    $display("%0d inside the cardioid, %0d never escaped, %0d mismatches.",
             sb.n_inside, sb.n_bounded, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("mandelbrot_escape_time_pixel_tb OK");
    end else begin
      $display("mandelbrot_escape_time_pixel_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mep_pkg.sv
hdl/mep_ctrl.sv
hdl/mep_dp.sv
hdl/mandelbrot_escape_time_pixel.sv
tb/mandelbrot_escape_time_pixel_tb.sv
